FILE: hw/rtl/siar_pkg.sv
package siar_pkg;

  // word and field widths
  localparam int WORD_BITS  = 32;
  localparam int CNT_BITS   = $clog2(WORD_BITS + 1);
  localparam int IDX_BITS   = $clog2(WORD_BITS);
  localparam int RADIX_BITS = 6;
  localparam int DIGIT_BITS = 6;
  localparam int CHAR_BITS  = 7;

  // radix limits and reset value
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);

  // character codes
  localparam logic [DIGIT_BITS-1:0] DIGIT_MAX  = DIGIT_BITS'(35);
  localparam logic [DIGIT_BITS-1:0] DIGIT_TEN  = DIGIT_BITS'(10);
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_BITS-1:0]  CHAR_ALPHA = 7'h57;  // 'a' minus ten
  localparam logic [CHAR_BITS-1:0]  CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_BITS-1:0]  CHAR_NONE  = 7'h00;

  // conversion sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_SIGN,
    S_FETCH,
    S_EMIT,
    S_BAD
  } state_t;

  // divider control
  typedef struct packed {
    logic load;   // take a new dividend, clear remainder
    logic clear;  // clear remainder, keep quotient as next dividend
    logic step;   // one restoring division step
  } div_ctl_t;

  // digit value to lower-case ascii
  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    logic [DIGIT_BITS-1:0] dc;
    dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    if (dc < DIGIT_TEN) begin
      return CHAR_ZERO + {1'b0, dc};
    end else begin
      return CHAR_ALPHA + {1'b0, dc};
    end
  endfunction

endpackage

FILE: hw/rtl/siar_div.sv
module siar_div import siar_pkg::*; (
  input  logic                  clk,
  input  div_ctl_t              ctl,
  input  logic [WORD_BITS-1:0]  dividend,
  input  logic [RADIX_BITS-1:0] divisor,
  output logic [WORD_BITS-1:0]  quotient,
  output logic [RADIX_BITS-1:0] remainder
);

  logic [WORD_BITS-1:0]  quo;
  logic [RADIX_BITS-1:0] rem;
  logic [RADIX_BITS:0]   trial;
  logic [RADIX_BITS:0]   diff;
  logic                  take;

  // shift in next dividend bit and try the subtract
  assign trial = {rem, quo[WORD_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = (trial >= {1'b0, divisor});

  // restoring division, one quotient bit per cycle while step is set
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quo <= dividend;
      rem <= '0;
    end else if (ctl.clear) begin
      rem <= '0;
    end else if (ctl.step) begin
      quo <= {quo[WORD_BITS-2:0], take};
      rem <= take ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: hw/rtl/signed_int_to_ascii_radix.sv
// each digit takes the division steps and a store, then comes a leading minus for a
// negative value and a fetch and an emit per character; busy stays high until the last word
// of a number is out, so one number is converted at a time (a number has at most
// 32 digits). an invalid radix gives a single word, flagged invalid, after start.
// words are strobed for one cycle each and cannot be stalled.
// rst is synchronous, active high: sequencer idle, radix back to 10.
module signed_int_to_ascii_radix import siar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RADIX_BITS-1:0] cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic [WORD_BITS-1:0]  value,
  output logic                  strobe,
  output logic [CHAR_BITS-1:0]  out_char,
  output logic                  last,
  output logic                  invalid
);

  state_t                state;
  state_t                state_next;
  logic [RADIX_BITS-1:0] radix;
  logic [CNT_BITS-1:0]   count;
  logic [IDX_BITS-1:0]   bit_cnt;
  logic                  is_neg;
  logic [DIGIT_BITS-1:0] rd_digit;
  logic [DIGIT_BITS-1:0] store [WORD_BITS];

  logic                  accept;
  logic                  radix_ok;
  logic [WORD_BITS-1:0]  mag;
  logic [WORD_BITS-1:0]  quotient;
  logic [RADIX_BITS-1:0] remainder;
  logic                  quo_zero;
  logic                  count_full;
  logic                  bit_done;
  logic [CNT_BITS-1:0]   cnt_m1;
  div_ctl_t              div_ctl;

  logic                  store_we;
  logic                  emit_vld;
  logic [CHAR_BITS-1:0]  emit_char;
  logic                  emit_last;
  logic                  emit_bad;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign radix_ok   = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign mag        = value[WORD_BITS-1] ? (~value + 1'b1) : value;
  assign quo_zero   = (quotient == '0);
  assign count_full = (count == CNT_BITS'(WORD_BITS - 1));
  assign bit_done   = (bit_cnt == IDX_BITS'(WORD_BITS - 1));
  assign cnt_m1     = count - 1'b1;

  // digit divider
  siar_div u_div (
    .clk       (clk),
    .ctl       (div_ctl),
    .dividend  (mag),
    .divisor   (radix),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = radix_ok ? S_DIV : S_BAD;
        end
      end
      S_DIV: begin
        if (bit_done) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        if (quo_zero || count_full) begin
          state_next = is_neg ? S_SIGN : S_FETCH;
        end else begin
          state_next = S_DIV;
        end
      end
      S_SIGN:  state_next = S_FETCH;
      S_FETCH: state_next = S_EMIT;
      S_EMIT: begin
        state_next = (count == CNT_BITS'(1)) ? S_IDLE : S_FETCH;
      end
      S_BAD:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control and result words per state
  always_comb begin
    div_ctl   = '0;
    store_we  = 1'b0;
    emit_vld  = 1'b0;
    emit_char = CHAR_NONE;
    emit_last = 1'b0;
    emit_bad  = 1'b0;
    case (state)
      S_IDLE:  div_ctl.load = accept && radix_ok;
      S_DIV:   div_ctl.step = 1'b1;
      S_STORE: begin
        store_we      = 1'b1;
        div_ctl.clear = 1'b1;
      end
      S_SIGN: begin
        emit_vld  = 1'b1;
        emit_char = CHAR_MINUS;
      end
      S_FETCH: ;
      S_EMIT: begin
        emit_vld  = 1'b1;
        emit_char = digit_char(rd_digit);
        emit_last = (count == CNT_BITS'(1));
      end
      S_BAD: begin
        emit_vld  = 1'b1;
        emit_last = 1'b1;
        emit_bad  = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer, counters and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      radix   <= RADIX_RESET;
      count   <= '0;
      bit_cnt <= '0;
      is_neg  <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit_vld;
      if (cfg_we) begin
        radix <= cfg_wdata;
      end
      if (div_ctl.load) begin
        is_neg  <= value[WORD_BITS-1];
        count   <= '0;
        bit_cnt <= '0;
      end else if (state == S_DIV) begin
        bit_cnt <= bit_cnt + 1'b1;
      end else if (state == S_STORE) begin
        count   <= count + 1'b1;
        bit_cnt <= '0;
      end else if (state == S_EMIT) begin
        count <= cnt_m1;
      end
    end
  end

  // result word registers
  always_ff @(posedge clk) begin
    if (emit_vld) begin
      out_char <= emit_char;
      last     <= emit_last;
      invalid  <= emit_bad;
    end
  end

  // digit store, least significant digit at entry zero
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[count[IDX_BITS-1:0]] <= remainder;
    end
    if (state == S_FETCH) begin
      rd_digit <= store[cnt_m1[IDX_BITS-1:0]];
    end
  end

endmodule
